>>> rtl/core/dfb_pkg.sv
// Shared types, constants and ASCII helpers for the dispenser frame builder.
`timescale 1ns / 1ps

package dfb_pkg;

    localparam int FRAME_LEN   = 23;
    localparam int DEC_DIGITS  = 6;
    localparam int IN_WIDTH    = 72;
    localparam int OUT_WIDTH   = 8;
    localparam int RECIP_SHIFT = 23;

    // ceil(2^23 / 10): exact quotient by ten for any 20-bit value
    localparam logic [19:0] RECIP_TEN = 20'd838861;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    typedef logic [4:0] idx_t;
    typedef logic [2:0] dcnt_t;

    localparam idx_t LAST_IDX = 5'(FRAME_LEN - 1);

    typedef struct packed {
        logic [7:0]       pump_number;
        logic [3:0]       command_code;
        logic [5:0][3:0]  price_dig;   // [5] is the most significant digit
        logic [5:0][3:0]  volume_dig;
        logic [15:0]      status_word;
    } frame_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] base;
        base = (nib < 4'd10) ? 8'h30 : 8'h37;
        return base + {4'b0000, nib};
    endfunction

    function automatic logic [7:0] dec_ascii(input logic [3:0] dig);
        return 8'h30 + {4'b0000, dig};
    endfunction

endpackage

>>> rtl/core/dfb_front.sv
// Front end: accept a request and split price and volume into decimal digits.
`timescale 1ns / 1ps

module dfb_front #(
    parameter int IN_W = dfb_pkg::IN_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,
    output logic                   push_valid,
    input  logic                   push_ready,
    output dfb_pkg::frame_t        push_data
);
    import dfb_pkg::*;

    logic        busy_reg;
    dcnt_t       cnt_reg;
    logic [19:0] price_reg;
    logic [19:0] volume_reg;
    frame_t      rec_reg;

    logic        accept;
    logic        step;
    logic        done;
    logic [39:0] price_prod;
    logic [39:0] volume_prod;
    logic [19:0] price_q;
    logic [19:0] volume_q;
    logic [19:0] price_r;
    logic [19:0] volume_r;

    assign s_tready   = !busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign step       = busy_reg && (cnt_reg != dcnt_t'(DEC_DIGITS));
    assign done       = busy_reg && (cnt_reg == dcnt_t'(DEC_DIGITS));
    assign push_valid = done;
    assign push_data  = rec_reg;

    // Quotient by ten through the reciprocal, remainder by shift-add
    assign price_prod  = {20'd0, price_reg} * {20'd0, RECIP_TEN};
    assign volume_prod = {20'd0, volume_reg} * {20'd0, RECIP_TEN};
    assign price_q     = {3'b000, price_prod[39:RECIP_SHIFT]};
    assign volume_q    = {3'b000, volume_prod[39:RECIP_SHIFT]};
    assign price_r     = price_reg - ((price_q << 3) + (price_q << 1));
    assign volume_r    = volume_reg - ((volume_q << 3) + (volume_q << 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (step) begin
            cnt_reg <= cnt_reg + 3'd1;
        end else if (done && push_ready) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rec_reg.pump_number  <= s_tdata[7:0];
            rec_reg.command_code <= s_tdata[11:8];
            rec_reg.status_word  <= s_tdata[67:52];
            price_reg            <= s_tdata[31:12];
            volume_reg           <= s_tdata[51:32];
        end else if (step) begin
            // shift digits down, least significant settles at index 0
            rec_reg.price_dig  <= {price_r[3:0], rec_reg.price_dig[5:1]};
            rec_reg.volume_dig <= {volume_r[3:0], rec_reg.volume_dig[5:1]};
            price_reg          <= price_q;
            volume_reg         <= volume_q;
        end
    end

endmodule

>>> rtl/core/dfb_queue.sv
// Two-entry queue of digit records between front and back ends.
`timescale 1ns / 1ps

module dfb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  dfb_pkg::frame_t push_data,
    output logic            pop_valid,
    input  logic            pop,
    output dfb_pkg::frame_t pop_data
);
    import dfb_pkg::*;

    frame_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/dfb_back.sv
// Back end: serialize one digit record into 23 frame beats with checksum.
`timescale 1ns / 1ps

module dfb_back #(
    parameter int OUT_W = dfb_pkg::OUT_WIDTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    output logic            pop,
    input  dfb_pkg::frame_t pop_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic            m_tlast
);
    import dfb_pkg::*;

    logic             active_reg;
    idx_t             idx_reg;
    frame_t           frame_reg;
    logic [7:0]       xor_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic             m_last_reg;

    logic       slot_free;
    logic       load;
    logic       last_load;
    logic [7:0] byte_val;

    assign slot_free = !m_valid_reg || m_tready;
    assign load      = active_reg && slot_free;
    assign last_load = load && (idx_reg == LAST_IDX);
    assign pop       = pop_valid && (!active_reg || last_load);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        unique case (idx_reg)
            5'd0:    byte_val = SOH_BYTE;
            5'd1:    byte_val = hex_ascii(frame_reg.pump_number[7:4]);
            5'd2:    byte_val = hex_ascii(frame_reg.pump_number[3:0]);
            5'd3:    byte_val = hex_ascii(frame_reg.command_code);
            5'd4:    byte_val = STX_BYTE;
            5'd5:    byte_val = dec_ascii(frame_reg.price_dig[5]);
            5'd6:    byte_val = dec_ascii(frame_reg.price_dig[4]);
            5'd7:    byte_val = dec_ascii(frame_reg.price_dig[3]);
            5'd8:    byte_val = dec_ascii(frame_reg.price_dig[2]);
            5'd9:    byte_val = dec_ascii(frame_reg.price_dig[1]);
            5'd10:   byte_val = dec_ascii(frame_reg.price_dig[0]);
            5'd11:   byte_val = dec_ascii(frame_reg.volume_dig[5]);
            5'd12:   byte_val = dec_ascii(frame_reg.volume_dig[4]);
            5'd13:   byte_val = dec_ascii(frame_reg.volume_dig[3]);
            5'd14:   byte_val = dec_ascii(frame_reg.volume_dig[2]);
            5'd15:   byte_val = dec_ascii(frame_reg.volume_dig[1]);
            5'd16:   byte_val = dec_ascii(frame_reg.volume_dig[0]);
            5'd17:   byte_val = hex_ascii(frame_reg.status_word[15:12]);
            5'd18:   byte_val = hex_ascii(frame_reg.status_word[11:8]);
            5'd19:   byte_val = hex_ascii(frame_reg.status_word[7:4]);
            5'd20:   byte_val = hex_ascii(frame_reg.status_word[3:0]);
            5'd21:   byte_val = ETX_BYTE;
            5'd22:   byte_val = xor_reg;
            default: byte_val = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end else if (last_load) begin
                active_reg <= 1'b0;
            end else if (load) begin
                idx_reg <= idx_reg + 5'd1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            frame_reg <= pop_data;
        end
        if (load) begin
            m_data_reg <= OUT_W'(byte_val);
            m_last_reg <= (idx_reg == LAST_IDX);
            // SOH stays out of the checksum
            xor_reg    <= (idx_reg == '0) ? 8'h00 : (xor_reg ^ byte_val);
        end
    end

endmodule

>>> rtl/core/dispenser_frame_builder_top.sv
// Top level of the dispenser frame builder.
`timescale 1ns / 1ps

// Each request beat (dispenser number, command, price, volume, status) becomes
// one 23-beat ASCII frame on the master side: SOH, two hex digits of the
// dispenser number, one hex digit of the command, STX, six decimal digits of
// price, six of volume, four hex digits of status, ETX and an XOR checksum of
// frame bytes 1 to 21. Hex letters are upper case, digits leave most
// significant first, and price or volume above 999999 loses its upper digits.
// m_tlast marks the checksum beat. The front end takes a request, splits
// price and volume into digits (one digit per cycle through a reciprocal
// multiply by one tenth) and offers the digit record to a two-entry queue;
// it takes no new request until that record is handed on. The back end
// sends one beat per cycle while m_tready stays high, so the serializer
// sets sustained throughput; frames follow each other back to back while
// m_tready stays high and a record waits in the queue. On an idle block a
// request passes the front end digit steps, the queue, the back end frame
// register and output register before its first beat shows on m_tvalid.

module dispenser_frame_builder_top #(
    parameter int IN_W  = dfb_pkg::IN_WIDTH,
    parameter int OUT_W = dfb_pkg::OUT_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata, lowest bit up: pump_number[7:0], command_code[11:8],
    // unit_price[31:12], fuel_volume[51:32], status_word[67:52], zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata: frame_byte[7:0]
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast    // last_byte
);
    import dfb_pkg::*;

    logic   push_valid;
    logic   push_ready;
    frame_t push_data;
    logic   pop_valid;
    logic   pop;
    frame_t pop_data;

    // Convert the request into a digit record
    dfb_front #(
        .IN_W (IN_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple conversion from serialization
    dfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // Serialize the record into frame beats
    dfb_back #(
        .OUT_W (OUT_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/core/dfb_checker.sv
// Port-level checks for the dispenser frame builder, bound to the top level.
`timescale 1ns / 1ps

module dfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import dfb_pkg::*;

    idx_t beat_cnt_reg;

    // Track the beat position within the current frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_cnt_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            beat_cnt_reg <= m_tlast ? '0 : (beat_cnt_reg + 5'd1);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_frame_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (beat_cnt_reg == LAST_IDX)))
        else $error("tlast not on beat 23 of the frame");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (beat_cnt_reg == '0) |-> (m_tdata == SOH_BYTE))
        else $error("frame does not open with SOH");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while conversion in progress");

endmodule

bind dispenser_frame_builder_top dfb_checker u_dfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
